>>> src/scdb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scdb_pkg
// Shared types and constants of the SATA command descriptor builder.
// ----------------------------------------------------------------------------
package scdb_pkg;

    // PRDT geometry
    localparam int MAX_PRDT_ENTRIES  = 8;
    localparam int SECTORS_PER_ENTRY = 16;
    localparam int SECTOR_BYTES      = 512;
    localparam int MAX_SECTORS       = MAX_PRDT_ENTRIES * SECTORS_PER_ENTRY;
    localparam int SEC_W             = $clog2(MAX_SECTORS + 1);
    localparam logic [31:0] ENTRY_STEP_BYTES = 32'(SECTORS_PER_ENTRY * SECTOR_BYTES);

    // ATA commands and task-file bits
    localparam logic [7:0] CMD_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0] CMD_WRITE_DMA_EXT = 8'h35;
    localparam logic [7:0] TF_BUSY           = 8'h80;
    localparam logic [7:0] TF_DRQ            = 8'h08;

    // Configuration register indexes
    localparam logic CFG_PORT_COUNT   = 1'b0;
    localparam logic CFG_PHYS_OFFSET  = 1'b1;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_PORT  = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_BAD_COUNT = 3'd3,
        ST_DEV_BUSY  = 3'd4
    } status_code_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_HEADER,
        S_ENTRY
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming request
        logic check;       // evaluate checks, set up the PRDT walk
        logic advance;     // step to the next PRDT entry
        logic show_entry;  // present an entry rather than the header
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic error;       // request failed a check
        logic fin;         // current entry is the final one
    } dp_status_t;

endpackage
`default_nettype wire

>>> src/scdb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scdb_ctrl
// Sequencer: accept a request, check it, emit the header, walk the entries if it passed.
// ----------------------------------------------------------------------------
module scdb_ctrl
    import scdb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    output dp_cmd_t         dp_cmd,
    input  wire dp_status_t dp_status
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_HEADER;
            end
            S_HEADER:
            begin
                if (!out_stall)
                begin
                    state_next = dp_status.error ? S_IDLE : S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                if (!out_stall && dp_status.fin)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall           = 1'b1;
        out_valid          = 1'b0;
        dp_cmd             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall       = 1'b0;
                dp_cmd.capture = in_valid;
            end
            S_CHECK:
            begin
                dp_cmd.check   = 1'b1;
            end
            S_HEADER:
            begin
                out_valid      = 1'b1;
            end
            S_ENTRY:
            begin
                out_valid         = 1'b1;
                dp_cmd.show_entry = 1'b1;
                dp_cmd.advance    = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Requests are taken only with no result pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("request taken while a result is pending");

    // The header always follows the check cycle
    a_check_then_header: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |=> state_reg == S_HEADER)
        else $error("check not followed by header");

    // Entries are emitted only for a request that passed its checks
    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ENTRY |-> !dp_status.error)
        else $error("entry emitted for a failed request");

endmodule
`default_nettype wire

>>> src/scdb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scdb_dp
// Datapath: request and configuration registers, checks, PRDT address walk.
// ----------------------------------------------------------------------------
module scdb_dp
    import scdb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic [5:0]  port_index,
    input  wire logic        is_write,
    input  wire logic [47:0] start_lba,
    input  wire logic [15:0] sector_count,
    input  wire logic [63:0] buffer_address,
    input  wire logic [31:0] slots_in_use,
    input  wire logic [7:0]  task_file_status,
    input  wire dp_cmd_t     dp_cmd,
    output dp_status_t       dp_status,
    output logic             kind,
    output logic [2:0]       status,
    output logic [4:0]       slot,
    output logic             write_flag,
    output logic [7:0]       command_code,
    output logic [47:0]      fis_lba,
    output logic [7:0]       fis_count,
    output logic [3:0]       prdt_length,
    output logic [31:0]      entry_address,
    output logic [12:0]      entry_bytes_minus_one,
    output logic             last
);

    // Configuration; only the low word of the offset reaches a 32-bit address
    logic [5:0]  port_count_reg;
    logic [31:0] offset_lo_reg;

    // Captured request
    logic [5:0]  port_reg;
    logic        wr_reg;
    logic [47:0] lba_reg;
    logic [15:0] count_reg;
    logic [31:0] buf_lo_reg;
    logic [31:0] busy_reg;
    logic [7:0]  tf_reg;

    // Check results and PRDT walk
    status_code_t     status_reg;
    logic [4:0]       slot_reg;
    logic [3:0]       entries_reg;
    logic [31:0]      addr_reg;
    logic [SEC_W-1:0] remaining_reg;

    status_code_t     status_next;
    logic [4:0]       slot_next;
    logic [31:0]      low_zero;
    logic [15:0]      entries_wide;
    logic             fin;
    logic [SEC_W-1:0] secs;
    logic [31:0]      bytes_full;
    logic             hdr_ok;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= '0;
            offset_lo_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PORT_COUNT:  port_count_reg <= cfg_data[5:0];
                CFG_PHYS_OFFSET: offset_lo_reg  <= cfg_data[31:0];
                default:         port_count_reg <= port_count_reg;
            endcase
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            port_reg   <= port_index;
            wr_reg     <= is_write;
            lba_reg    <= start_lba;
            count_reg  <= sector_count;
            buf_lo_reg <= buffer_address[31:0];
            busy_reg   <= slots_in_use;
            tf_reg     <= task_file_status;
        end
    end

    // Isolate the lowest clear slot bit and encode it
    always_comb
    begin
        low_zero  = ~busy_reg & (busy_reg + 32'd1);
        slot_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (low_zero[i])
            begin
                slot_next = slot_next | 5'(i);
            end
        end
    end

    // Checks in priority order
    always_comb
    begin
        priority if (port_reg >= port_count_reg)
        begin
            status_next = ST_BAD_PORT;
        end
        else if (busy_reg == '1)
        begin
            status_next = ST_NO_SLOT;
        end
        else if (count_reg == '0 || count_reg > 16'(MAX_SECTORS))
        begin
            status_next = ST_BAD_COUNT;
        end
        else if ((tf_reg & (TF_BUSY | TF_DRQ)) != '0)
        begin
            status_next = ST_DEV_BUSY;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    assign entries_wide = (count_reg - 16'd1) / 16'(SECTORS_PER_ENTRY) + 16'd1;

    // Register the check results and advance the entry walk
    always_ff @(posedge clk)
    begin
        if (dp_cmd.check)
        begin
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            entries_reg   <= entries_wide[3:0];
            addr_reg      <= buf_lo_reg - offset_lo_reg;
            remaining_reg <= count_reg[SEC_W-1:0];
        end
        else if (dp_cmd.advance)
        begin
            addr_reg      <= addr_reg + ENTRY_STEP_BYTES;
            remaining_reg <= remaining_reg - SEC_W'(SECTORS_PER_ENTRY);
        end
    end

    // Size of the current entry
    assign fin        = remaining_reg <= SEC_W'(SECTORS_PER_ENTRY);
    assign secs       = fin ? remaining_reg : SEC_W'(SECTORS_PER_ENTRY);
    assign bytes_full = (32'(secs) * 32'(SECTOR_BYTES)) - 32'd1;

    assign dp_status.error = (status_reg != ST_OK);
    assign dp_status.fin   = fin;

    // Drive the result fields
    assign hdr_ok = !dp_cmd.show_entry && (status_reg == ST_OK);

    assign kind                  = dp_cmd.show_entry ? KIND_ENTRY : KIND_HEADER;
    assign status                = dp_cmd.show_entry ? 3'(ST_OK) : 3'(status_reg);
    assign slot                  = hdr_ok ? slot_reg : '0;
    assign write_flag            = hdr_ok & wr_reg;
    assign command_code          = !hdr_ok ? 8'h00 :
                                   (wr_reg ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT);
    assign fis_lba               = hdr_ok ? lba_reg : '0;
    assign fis_count             = hdr_ok ? count_reg[7:0] : '0;
    assign prdt_length           = hdr_ok ? entries_reg : '0;
    assign entry_address         = dp_cmd.show_entry ? addr_reg : '0;
    assign entry_bytes_minus_one = dp_cmd.show_entry ? bytes_full[12:0] : '0;
    assign last                  = dp_cmd.show_entry ? fin : (status_reg != ST_OK);

endmodule
`default_nettype wire

>>> src/sata_command_descriptor_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sata_command_descriptor_builder
// Checks a SATA read/write request and emits the AHCI command header
// followed by its PRDT entries.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   in_valid / in_stall   port_index .. task_file_status
//  result    out_valid / out_stall kind .. last
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A request passes an accept state and a check state, then gives one result
//  per cycle while not stalled: a header and up to MAX_PRDT_ENTRIES entries.
//  The sequencer handles one request at a time; the next is taken the cycle
//  after the last result is taken. Output stall holds the current result.
//  Reset clears the sequencer and the configuration registers.
// ----------------------------------------------------------------------------
module sata_command_descriptor_builder
    import scdb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  port_index,
    input  wire logic        is_write,
    input  wire logic [47:0] start_lba,
    input  wire logic [15:0] sector_count,
    input  wire logic [63:0] buffer_address,
    input  wire logic [31:0] slots_in_use,
    input  wire logic [7:0]  task_file_status,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [2:0]       status,
    output logic [4:0]       slot,
    output logic             write_flag,
    output logic [7:0]       command_code,
    output logic [47:0]      fis_lba,
    output logic [7:0]       fis_count,
    output logic [3:0]       prdt_length,
    output logic [31:0]      entry_address,
    output logic [12:0]      entry_bytes_minus_one,
    output logic             last
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Configuration is always accepted
    assign cfg_ready = 1'b1;

    scdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    scdb_dp u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write             (cfg_valid & cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .port_index            (port_index),
        .is_write              (is_write),
        .start_lba             (start_lba),
        .sector_count          (sector_count),
        .buffer_address        (buffer_address),
        .slots_in_use          (slots_in_use),
        .task_file_status      (task_file_status),
        .dp_cmd                (dp_cmd),
        .dp_status             (dp_status),
        .kind                  (kind),
        .status                (status),
        .slot                  (slot),
        .write_flag            (write_flag),
        .command_code          (command_code),
        .fis_lba               (fis_lba),
        .fis_count             (fis_count),
        .prdt_length           (prdt_length),
        .entry_address         (entry_address),
        .entry_bytes_minus_one (entry_bytes_minus_one),
        .last                  (last)
    );

endmodule
`default_nettype wire

>>> tb/scdb_descriptor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scdb_descriptor_checker
// Watches the configuration, request and result channels of the SATA command
// descriptor builder. Each accepted request is turned into the command header
// and PRDT entries it should produce. Each accepted result is compared with
// the oldest of those.
// ----------------------------------------------------------------------------
module scdb_descriptor_checker
    import scdb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [5:0]  port_index,
    input  wire logic        is_write,
    input  wire logic [47:0] start_lba,
    input  wire logic [15:0] sector_count,
    input  wire logic [63:0] buffer_address,
    input  wire logic [31:0] slots_in_use,
    input  wire logic [7:0]  task_file_status,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        kind,
    input  wire logic [2:0]  status,
    input  wire logic [4:0]  slot,
    input  wire logic        write_flag,
    input  wire logic [7:0]  command_code,
    input  wire logic [47:0] fis_lba,
    input  wire logic [7:0]  fis_count,
    input  wire logic [3:0]  prdt_length,
    input  wire logic [31:0] entry_address,
    input  wire logic [12:0] entry_bytes_minus_one,
    input  wire logic        last,
    output int               error_count,
    output int               outstanding
);

    typedef struct packed {
        logic         kind;
        status_code_t status;
        logic [4:0]   slot;
        logic         write_flag;
        logic [7:0]   command_code;
        logic [47:0]  fis_lba;
        logic [7:0]   fis_count;
        logic [3:0]   prdt_length;
        logic [31:0]  entry_address;
        logic [12:0]  entry_bytes_minus_one;
        logic         last;
    } descriptor_t;

    // Local copy of the configuration registers
    logic [5:0]  port_limit;
    logic [63:0] phys_offset;

    descriptor_t pending_descriptors[$];
    descriptor_t observed;
    descriptor_t wanted;
    int          mismatches;

    function automatic string describe(descriptor_t d);
        return $sformatf({"kind=%0d status=%0d slot=%0d wr=%0d cmd=%h lba=%h cnt=%0d ",
                          "prdt=%0d addr=%h bytes-1=%0d last=%0d"},
                         d.kind, d.status, d.slot, d.write_flag, d.command_code,
                         d.fis_lba, d.fis_count, d.prdt_length, d.entry_address,
                         d.entry_bytes_minus_one, d.last);
    endfunction

    function automatic descriptor_t error_header(status_code_t code);
        descriptor_t d;
        d        = '0;
        d.status = code;
        d.last   = 1'b1;
        return d;
    endfunction

    // Queue the header and PRDT entries that one request should give
    function automatic void build_descriptors(input logic [5:0] port, input logic wr,
                                              input logic [47:0] lba,
                                              input logic [15:0] count,
                                              input logic [63:0] addr,
                                              input logic [31:0] busy,
                                              input logic [7:0] tf);
        descriptor_t d;
        int          free_slot;
        int          n_entries;
        int          left;
        int          secs;
        logic [63:0] phys;
        free_slot = -1;
        for (int i = 31; i >= 0; i--)
        begin
            if (!busy[i])
                free_slot = i;
        end
        // checks go in a fixed order: port, slot, count, device state
        if (port >= port_limit)
            pending_descriptors.push_back(error_header(ST_BAD_PORT));
        else if (free_slot < 0)
            pending_descriptors.push_back(error_header(ST_NO_SLOT));
        else if (count == 0 || count > MAX_SECTORS)
            pending_descriptors.push_back(error_header(ST_BAD_COUNT));
        else if ((tf & (TF_BUSY | TF_DRQ)) != 0)
            pending_descriptors.push_back(error_header(ST_DEV_BUSY));
        else
        begin
            n_entries      = (int'(count) - 1) / SECTORS_PER_ENTRY + 1;
            d              = '0;
            d.kind         = KIND_HEADER;
            d.status       = ST_OK;
            d.slot         = 5'(free_slot);
            d.write_flag   = wr;
            d.command_code = wr ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT;
            d.fis_lba      = lba;
            d.fis_count    = count[7:0];
            d.prdt_length  = 4'(n_entries);
            pending_descriptors.push_back(d);
            // walk the buffer in full entries, the final one takes the rest
            phys = addr - phys_offset;
            left = int'(count);
            for (int i = 0; i < n_entries; i++)
            begin
                secs                    = (i == n_entries - 1) ? left : SECTORS_PER_ENTRY;
                d                       = '0;
                d.kind                  = KIND_ENTRY;
                d.entry_address         = phys[31:0];
                d.entry_bytes_minus_one = 13'(secs * SECTOR_BYTES - 1);
                d.last                  = (i == n_entries - 1);
                pending_descriptors.push_back(d);
                phys = phys + 64'(ENTRY_STEP_BYTES);
                left = left - secs;
            end
        end
    endfunction

    // Track register writes, predict on each request, check each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_limit  = '0;
            phys_offset = '0;
            mismatches  = 0;
            pending_descriptors.delete();
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PORT_COUNT)
                    port_limit = cfg_data[5:0];
                else
                    phys_offset = cfg_data;
            end
            if (in_valid && !in_stall)
                build_descriptors(port_index, is_write, start_lba, sector_count,
                                  buffer_address, slots_in_use, task_file_status);
            if (out_valid && !out_stall)
            begin
                observed = {kind, status, slot, write_flag, command_code, fis_lba,
                            fis_count, prdt_length, entry_address,
                            entry_bytes_minus_one, last};
                if (pending_descriptors.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: %s", $time, describe(observed));
                end
                else
                begin
                    wanted = pending_descriptors.pop_front();
                    if (observed !== wanted)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("    expected %s", describe(wanted));
                            $display("    actual   %s", describe(observed));
                        end
                    end
                end
            end
            error_count <= mismatches;
            outstanding <= pending_descriptors.size();
        end
    end

endmodule

>>> tb/sata_command_descriptor_builder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sata_command_descriptor_builder_test
// Drives the descriptor builder with a directed set of requests covering the
// field extremes and every error status, then random requests under several
// port counts and address offsets, with random idling on both channels.
// Checking is done by scdb_descriptor_checker, instanced beside the block.
// ----------------------------------------------------------------------------
module sata_command_descriptor_builder_test
    import scdb_pkg::*;
();

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 70;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic        cfg_index        = CFG_PORT_COUNT;
    logic [63:0] cfg_data         = '0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic [5:0]  port_index       = '0;
    logic        is_write         = 1'b0;
    logic [47:0] start_lba        = '0;
    logic [15:0] sector_count     = '0;
    logic [63:0] buffer_address   = '0;
    logic [31:0] slots_in_use     = '0;
    logic [7:0]  task_file_status = '0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic        kind;
    logic [2:0]  status;
    logic [4:0]  slot;
    logic        write_flag;
    logic [7:0]  command_code;
    logic [47:0] fis_lba;
    logic [7:0]  fis_count;
    logic [3:0]  prdt_length;
    logic [31:0] entry_address;
    logic [12:0] entry_bytes_minus_one;
    logic        last;

    int          error_count;
    int          outstanding;
    int          cycle_count = 0;
    int          stall_left  = 0;
    int          calm_left   = 0;
    logic        quiet_tail  = 1'b0;
    logic        calm_inputs = 1'b0;

    sata_command_descriptor_builder DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .port_index            (port_index),
        .is_write              (is_write),
        .start_lba             (start_lba),
        .sector_count          (sector_count),
        .buffer_address        (buffer_address),
        .slots_in_use          (slots_in_use),
        .task_file_status      (task_file_status),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .kind                  (kind),
        .status                (status),
        .slot                  (slot),
        .write_flag            (write_flag),
        .command_code          (command_code),
        .fis_lba               (fis_lba),
        .fis_count             (fis_count),
        .prdt_length           (prdt_length),
        .entry_address         (entry_address),
        .entry_bytes_minus_one (entry_bytes_minus_one),
        .last                  (last)
    );

    scdb_descriptor_checker descriptor_check (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .port_index            (port_index),
        .is_write              (is_write),
        .start_lba             (start_lba),
        .sector_count          (sector_count),
        .buffer_address        (buffer_address),
        .slots_in_use          (slots_in_use),
        .task_file_status      (task_file_status),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .kind                  (kind),
        .status                (status),
        .slot                  (slot),
        .write_flag            (write_flag),
        .command_code          (command_code),
        .fis_lba               (fis_lba),
        .fis_count             (fis_count),
        .prdt_length           (prdt_length),
        .entry_address         (entry_address),
        .entry_bytes_minus_one (entry_bytes_minus_one),
        .last                  (last),
        .error_count           (error_count),
        .outstanding           (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result channel in random bursts, with calm stretches between
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 19);
        else if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(20, 120);
        out_stall <= !quiet_tail && stall_left > 0;
    end

    function automatic int idle_gap();
        if (quiet_tail || calm_inputs)
            return 0;
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    endfunction

    // Present one request, hold it until taken, then idle for the given gap
    task automatic send_request(input logic [5:0] port, input logic wr,
                                input logic [47:0] lba, input logic [15:0] count,
                                input logic [63:0] addr, input logic [31:0] slots,
                                input logic [7:0] tf, input int gap);
        port_index       <= port;
        is_write         <= wr;
        start_lba        <= lba;
        sector_count     <= count;
        buffer_address   <= addr;
        slots_in_use     <= slots;
        task_file_status <= tf;
        in_valid         <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop the request channel and wait for every expected result
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers back to back
    task automatic write_config(input logic [5:0] ports, input logic [63:0] offset);
        cfg_index <= CFG_PORT_COUNT;
        cfg_data  <= 64'(ports);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_PHYS_OFFSET;
        cfg_data  <= offset;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [5:0]  limit;
        logic [63:0] offset;
        logic        well;
        int          k;
        logic [5:0]  port;
        logic [15:0] count;
        logic [31:0] slots;
        logic [7:0]  tf;
        logic [63:0] addr;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no ports configured every request is refused
        send_request(6'd0, 1'b0, '0, 16'd1, '0, '0, 8'h00, idle_gap());
        settle();
        write_config(6'd32, '0);

        // Field extremes and each error status
        send_request(6'd31, 1'b0, '0, 16'd1, '0, '0, 8'h00, idle_gap());
        send_request(6'd32, 1'b0, '0, 16'd1, '0, '0, 8'h00, idle_gap());
        send_request(6'd63, 1'b1, '1, 16'd8, '1, '0, 8'h00, idle_gap());
        send_request(6'd5, 1'b1, '1, 16'd128, '1, 32'h7FFF_FFFF, 8'h77, idle_gap());
        send_request(6'd0, 1'b0, 48'h1234_5678_9ABC, 16'd4, 64'h1000, '1, 8'h00,
                     idle_gap());
        send_request(6'd1, 1'b0, '0, 16'd0, '0, '0, 8'h00, idle_gap());
        send_request(6'd2, 1'b1, '0, 16'd129, '0, '0, 8'h00, idle_gap());
        send_request(6'd3, 1'b0, '0, 16'hFFFF, '0, '0, 8'h00, idle_gap());
        send_request(6'd4, 1'b0, 48'h0000_0000_0100, 16'd16, 64'h8000, 32'h1, 8'h00,
                     idle_gap());
        send_request(6'd4, 1'b1, 48'h8000_0000_0000, 16'd17, 64'hFFFF_FFFF_FFFF_E000,
                     32'h3, 8'h00, idle_gap());
        send_request(6'd6, 1'b0, '0, 16'd10, '0, '0, TF_BUSY, idle_gap());
        send_request(6'd6, 1'b0, '0, 16'd10, '0, '0, TF_DRQ, idle_gap());
        send_request(6'd6, 1'b1, '0, 16'd10, '0, '0, 8'hFF, idle_gap());
        // A request failing several checks reports the first in order
        send_request(6'd40, 1'b0, '0, 16'd0, '0, '1, TF_BUSY, idle_gap());
        send_request(6'd7, 1'b0, '0, 16'd0, '0, '1, TF_BUSY, idle_gap());
        send_request(6'd7, 1'b0, '0, 16'd0, '0, '0, TF_BUSY, idle_gap());
        send_request(6'd8, 1'b1, 48'hFFFF_0000_FFFF, 16'd100, 64'h0000_0001_FFFF_F000,
                     32'h0000_FFFF, 8'h00, idle_gap());
        settle();

        // Offset of all ones: physical addresses wrap past zero
        write_config(6'd1, '1);
        send_request(6'd0, 1'b0, 48'h0000_0000_0001, 16'd33, '0, '0, 8'h00, idle_gap());
        send_request(6'd1, 1'b0, '0, 16'd33, '0, '0, 8'h00, idle_gap());
        send_request(6'd0, 1'b1, '1, 16'd127, 64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFE,
                     8'h00, idle_gap());
        settle();

        // Random requests, mostly well formed, under several register settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    limit  = 6'd32;
                    offset = '0;
                end
                1:
                begin
                    limit  = 6'd1;
                    offset = '1;
                end
                default:
                begin
                    limit  = 6'($urandom_range(1, 32));
                    offset = {$urandom, $urandom};
                end
            endcase
            write_config(limit, offset);
            if (p == RANDOM_PHASES - 1)
                quiet_tail <= 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 20 == 0)
                    calm_inputs = ($urandom_range(0, 3) == 0);
                well = ($urandom_range(0, 3) != 0);
                if (well)
                begin
                    port = 6'($urandom_range(0, int'(limit) - 1));
                    case ($urandom_range(0, 3))
                        0:       count = 16'($urandom_range(1, SECTORS_PER_ENTRY));
                        1:       count = 16'($urandom_range(1, MAX_SECTORS));
                        2:       count = 16'(SECTORS_PER_ENTRY *
                                             $urandom_range(1, MAX_PRDT_ENTRIES));
                        default: count = 16'(SECTORS_PER_ENTRY *
                                             $urandom_range(0, MAX_PRDT_ENTRIES - 1) + 1);
                    endcase
                    // lowest free slot lands anywhere in the mask
                    k     = $urandom_range(0, 31);
                    slots = ($urandom & (32'hFFFF_FFFE << k)) | ((32'h1 << k) - 32'h1);
                    tf    = 8'($urandom_range(0, 255)) & ~(TF_BUSY | TF_DRQ);
                end
                else
                begin
                    port  = 6'($urandom_range(0, 63));
                    count = 16'($urandom_range(0, 65535));
                    slots = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
                    tf    = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 1) == 0)
                    addr = offset + 64'($urandom_range(0, 1 << 20));
                else
                    addr = {$urandom, $urandom};
                send_request(port, 1'($urandom_range(0, 1)), 48'({$urandom, $urandom}),
                             count, addr, slots, tf, idle_gap());
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
